/* hw/rtl/hpe_pkg.sv */
// Package: HPACK Huffman code tables and shared types.
package hpe_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned CodeW  = 30;
  localparam int unsigned LenW   = 5;
  localparam int unsigned AccW   = 37;
  localparam int unsigned CntW   = 6;
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [AccW-1:0] acc;
    logic [CntW-1:0] n;
    logic            fin;
  } work_t;

  function automatic logic [CodeW-1:0] code_lut(input logic [SymW-1:0] s);
    logic [CodeW-1:0] c;
    unique case (s)
      8'd0: c=30'h1ff8; 8'd1: c=30'h7fffd8; 8'd2: c=30'hfffffe2; 8'd3: c=30'hfffffe3;
      8'd4: c=30'hfffffe4; 8'd5: c=30'hfffffe5; 8'd6: c=30'hfffffe6; 8'd7: c=30'hfffffe7;
      8'd8: c=30'hfffffe8; 8'd9: c=30'hffffea; 8'd10: c=30'h3ffffffc; 8'd11: c=30'hfffffe9;
      8'd12: c=30'hfffffea; 8'd13: c=30'h3ffffffd; 8'd14: c=30'hfffffeb; 8'd15: c=30'hfffffec;
      8'd16: c=30'hfffffed; 8'd17: c=30'hfffffee; 8'd18: c=30'hfffffef; 8'd19: c=30'hffffff0;
      8'd20: c=30'hffffff1; 8'd21: c=30'hffffff2; 8'd22: c=30'h3ffffffe; 8'd23: c=30'hffffff3;
      8'd24: c=30'hffffff4; 8'd25: c=30'hffffff5; 8'd26: c=30'hffffff6; 8'd27: c=30'hffffff7;
      8'd28: c=30'hffffff8; 8'd29: c=30'hffffff9; 8'd30: c=30'hffffffa; 8'd31: c=30'hffffffb;
      8'd32: c=30'h14; 8'd33: c=30'h3f8; 8'd34: c=30'h3f9; 8'd35: c=30'hffa;
      8'd36: c=30'h1ff9; 8'd37: c=30'h15; 8'd38: c=30'hf8; 8'd39: c=30'h7fa;
      8'd40: c=30'h3fa; 8'd41: c=30'h3fb; 8'd42: c=30'hf9; 8'd43: c=30'h7fb;
      8'd44: c=30'hfa; 8'd45: c=30'h16; 8'd46: c=30'h17; 8'd47: c=30'h18;
      8'd48: c=30'h0; 8'd49: c=30'h1; 8'd50: c=30'h2; 8'd51: c=30'h19;
      8'd52: c=30'h1a; 8'd53: c=30'h1b; 8'd54: c=30'h1c; 8'd55: c=30'h1d;
      8'd56: c=30'h1e; 8'd57: c=30'h1f; 8'd58: c=30'h5c; 8'd59: c=30'hfb;
      8'd60: c=30'h7ffc; 8'd61: c=30'h20; 8'd62: c=30'hffb; 8'd63: c=30'h3fc;
      8'd64: c=30'h1ffa; 8'd65: c=30'h21; 8'd66: c=30'h5d; 8'd67: c=30'h5e;
      8'd68: c=30'h5f; 8'd69: c=30'h60; 8'd70: c=30'h61; 8'd71: c=30'h62;
      8'd72: c=30'h63; 8'd73: c=30'h64; 8'd74: c=30'h65; 8'd75: c=30'h66;
      8'd76: c=30'h67; 8'd77: c=30'h68; 8'd78: c=30'h69; 8'd79: c=30'h6a;
      8'd80: c=30'h6b; 8'd81: c=30'h6c; 8'd82: c=30'h6d; 8'd83: c=30'h6e;
      8'd84: c=30'h6f; 8'd85: c=30'h70; 8'd86: c=30'h71; 8'd87: c=30'h72;
      8'd88: c=30'hfc; 8'd89: c=30'h73; 8'd90: c=30'hfd; 8'd91: c=30'h1ffb;
      8'd92: c=30'h7fff0; 8'd93: c=30'h1ffc; 8'd94: c=30'h3ffc; 8'd95: c=30'h22;
      8'd96: c=30'h7ffd; 8'd97: c=30'h3; 8'd98: c=30'h23; 8'd99: c=30'h4;
      8'd100: c=30'h24; 8'd101: c=30'h5; 8'd102: c=30'h25; 8'd103: c=30'h26;
      8'd104: c=30'h27; 8'd105: c=30'h6; 8'd106: c=30'h74; 8'd107: c=30'h75;
      8'd108: c=30'h28; 8'd109: c=30'h29; 8'd110: c=30'h2a; 8'd111: c=30'h7;
      8'd112: c=30'h2b; 8'd113: c=30'h76; 8'd114: c=30'h2c; 8'd115: c=30'h8;
      8'd116: c=30'h9; 8'd117: c=30'h2d; 8'd118: c=30'h77; 8'd119: c=30'h78;
      8'd120: c=30'h79; 8'd121: c=30'h7a; 8'd122: c=30'h7b; 8'd123: c=30'h7ffe;
      8'd124: c=30'h7fc; 8'd125: c=30'h3ffd; 8'd126: c=30'h1ffd; 8'd127: c=30'hffffffc;
      8'd128: c=30'hfffe6; 8'd129: c=30'h3fffd2; 8'd130: c=30'hfffe7; 8'd131: c=30'hfffe8;
      8'd132: c=30'h3fffd3; 8'd133: c=30'h3fffd4; 8'd134: c=30'h3fffd5; 8'd135: c=30'h7fffd9;
      8'd136: c=30'h3fffd6; 8'd137: c=30'h7fffda; 8'd138: c=30'h7fffdb; 8'd139: c=30'h7fffdc;
      8'd140: c=30'h7fffdd; 8'd141: c=30'h7fffde; 8'd142: c=30'hffffeb; 8'd143: c=30'h7fffdf;
      8'd144: c=30'hffffec; 8'd145: c=30'hffffed; 8'd146: c=30'h3fffd7; 8'd147: c=30'h7fffe0;
      8'd148: c=30'hffffee; 8'd149: c=30'h7fffe1; 8'd150: c=30'h7fffe2; 8'd151: c=30'h7fffe3;
      8'd152: c=30'h7fffe4; 8'd153: c=30'h1fffdc; 8'd154: c=30'h3fffd8; 8'd155: c=30'h7fffe5;
      8'd156: c=30'h3fffd9; 8'd157: c=30'h7fffe6; 8'd158: c=30'h7fffe7; 8'd159: c=30'hffffef;
      8'd160: c=30'h3fffda; 8'd161: c=30'h1fffdd; 8'd162: c=30'hfffe9; 8'd163: c=30'h3fffdb;
      8'd164: c=30'h3fffdc; 8'd165: c=30'h7fffe8; 8'd166: c=30'h7fffe9; 8'd167: c=30'h1fffde;
      8'd168: c=30'h7fffea; 8'd169: c=30'h3fffdd; 8'd170: c=30'h3fffde; 8'd171: c=30'hfffff0;
      8'd172: c=30'h1fffdf; 8'd173: c=30'h3fffdf; 8'd174: c=30'h7fffeb; 8'd175: c=30'h7fffec;
      8'd176: c=30'h1fffe0; 8'd177: c=30'h1fffe1; 8'd178: c=30'h3fffe0; 8'd179: c=30'h1fffe2;
      8'd180: c=30'h7fffed; 8'd181: c=30'h3fffe1; 8'd182: c=30'h7fffee; 8'd183: c=30'h7fffef;
      8'd184: c=30'hfffea; 8'd185: c=30'h3fffe2; 8'd186: c=30'h3fffe3; 8'd187: c=30'h3fffe4;
      8'd188: c=30'h7ffff0; 8'd189: c=30'h3fffe5; 8'd190: c=30'h3fffe6; 8'd191: c=30'h7ffff1;
      8'd192: c=30'h3ffffe0; 8'd193: c=30'h3ffffe1; 8'd194: c=30'hfffeb; 8'd195: c=30'h7fff1;
      8'd196: c=30'h3fffe7; 8'd197: c=30'h7ffff2; 8'd198: c=30'h3fffe8; 8'd199: c=30'h1ffffec;
      8'd200: c=30'h3ffffe2; 8'd201: c=30'h3ffffe3; 8'd202: c=30'h3ffffe4; 8'd203: c=30'h7ffffde;
      8'd204: c=30'h7ffffdf; 8'd205: c=30'h3ffffe5; 8'd206: c=30'hfffff1; 8'd207: c=30'h1ffffed;
      8'd208: c=30'h7fff2; 8'd209: c=30'h1fffe3; 8'd210: c=30'h3ffffe6; 8'd211: c=30'h7ffffe0;
      8'd212: c=30'h7ffffe1; 8'd213: c=30'h3ffffe7; 8'd214: c=30'h7ffffe2; 8'd215: c=30'hfffff2;
      8'd216: c=30'h1fffe4; 8'd217: c=30'h1fffe5; 8'd218: c=30'h3ffffe8; 8'd219: c=30'h3ffffe9;
      8'd220: c=30'hffffffd; 8'd221: c=30'h7ffffe3; 8'd222: c=30'h7ffffe4; 8'd223: c=30'h7ffffe5;
      8'd224: c=30'hfffec; 8'd225: c=30'hfffff3; 8'd226: c=30'hfffed; 8'd227: c=30'h1fffe6;
      8'd228: c=30'h3fffe9; 8'd229: c=30'h1fffe7; 8'd230: c=30'h1fffe8; 8'd231: c=30'h7ffff3;
      8'd232: c=30'h3fffea; 8'd233: c=30'h3fffeb; 8'd234: c=30'h1ffffee; 8'd235: c=30'h1ffffef;
      8'd236: c=30'hfffff4; 8'd237: c=30'hfffff5; 8'd238: c=30'h3ffffea; 8'd239: c=30'h7ffff4;
      8'd240: c=30'h3ffffeb; 8'd241: c=30'h7ffffe6; 8'd242: c=30'h3ffffec; 8'd243: c=30'h3ffffed;
      8'd244: c=30'h7ffffe7; 8'd245: c=30'h7ffffe8; 8'd246: c=30'h7ffffe9; 8'd247: c=30'h7ffffea;
      8'd248: c=30'h7ffffeb; 8'd249: c=30'hffffffe; 8'd250: c=30'h7ffffec; 8'd251: c=30'h7ffffed;
      8'd252: c=30'h7ffffee; 8'd253: c=30'h7ffffef; 8'd254: c=30'h7fffff0;
      default: c=30'h3ffffee;
    endcase
    return c;
  endfunction

  localparam logic [LenW-1:0] LenRom [256] = '{
    13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
    28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
    6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
    5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
    13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
    7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
    15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
    6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
    20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
    24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
    22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
    21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
    26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
    19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
    20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
    26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26
  };

endpackage

/* hw/rtl/hpe_stream_if.sv */
// Interfaces: input symbol and output byte channels.
interface hpe_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, symbol, last, input ready);
  modport sink   (input valid, symbol, last, output ready);
endinterface

interface hpe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

/* hw/rtl/hpack_huffman_string_encoder.sv */
// Top level: HPACK static Huffman string encoder.
// Each input transaction carries one string octet; its RFC 7541 Huffman code (5..30 bits) is
// looked up in a constant ROM and merged with up to 7 pending bits in the front end, and the
// merged word goes into a queue (two entries by default). The back end drains the head entry
// at one output byte per cycle while the receiver is ready, through a registered output stage;
// an entry that completes no byte is still popped, without emitting one. The front accepts back
// to back while the queue has room. On the last octet leftover bits are padded with ones and that
// byte is flagged out_last; pending state is cleared when that octet is accepted. An accepted
// octet is written into the queue and then into the registered output stage before it shows.
module hpack_huffman_string_encoder #(
  parameter int unsigned QueueDepth = hpe_pkg::QDepth
) (
  input logic clk_i,
  input logic rst_ni,
  hpe_sym_if.sink    in_if,
  hpe_byte_if.source out_if
);
  import hpe_pkg::*;

  work_t w_push, w_head;
  logic  push, full, pop, empty;

  hpe_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .symbol_i   (in_if.symbol),
    .last_i     (in_if.last),
    .push_o     (push),
    .full_i     (full),
    .work_o     (w_push)
  );

  hpe_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (w_push),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (w_head)
  );

  hpe_back u_back (
    .clk_i, .rst_ni,
    .empty_i     (empty),
    .work_i      (w_head),
    .pop_o       (pop),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_byte_o  (out_if.out_byte),
    .out_last_o  (out_if.out_last)
  );

`ifndef SYNTHESIS
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.out_last |-> !$isunknown(out_if.out_byte)) else $error("bad last");
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == !full) else $error("ready mismatch");
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop without head");
`endif
endmodule

/* hw/rtl/hpe_front.sv */
// Front end: code lookup, merge with pending bits, push work to queue.
module hpe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        symbol_i,
  input  logic              last_i,
  output logic              push_o,
  input  logic              full_i,
  output hpe_pkg::work_t    work_o
);
  import hpe_pkg::*;

  logic [6:0]      pbits_q, pbits_d;
  logic [2:0]      pcnt_q, pcnt_d;
  logic [CodeW-1:0] code;
  logic [LenW-1:0] clen;
  logic [AccW-1:0] acc;
  logic [CntW-1:0] n;
  logic [6:0]      mask;
  logic            fire;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign code       = code_lut(symbol_i);
  assign clen       = LenRom[symbol_i];
  assign acc        = ({{(AccW-7){1'b0}}, pbits_q} << clen) | {{(AccW-CodeW){1'b0}}, code};
  assign n          = CntW'(pcnt_q) + CntW'(clen);
  assign mask       = (7'(1) << n[2:0]) - 7'(1);

  assign push_o     = fire;
  assign work_o.acc = acc;
  assign work_o.n   = n;
  assign work_o.fin = last_i;

  always_comb begin
    pbits_d = pbits_q;
    pcnt_d  = pcnt_q;
    if (fire) begin
      if (last_i) begin
        pbits_d = '0;
        pcnt_d  = '0;
      end else begin
        pbits_d = acc[6:0] & mask;
        pcnt_d  = n[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbits_q <= '0;
      pcnt_q  <= '0;
    end else begin
      pbits_q <= pbits_d;
      pcnt_q  <= pcnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_i |=> pcnt_q == '0) else $error("pending count not cleared");
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> n >= CntW'(5) && n <= CntW'(37)) else $error("bit count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o) else $error("push into full queue");
`endif
endmodule

/* hw/rtl/hpe_queue.sv */
// Small FIFO of work entries between front and back.
module hpe_queue #(
  parameter int unsigned Depth = hpe_pkg::QDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hpe_pkg::work_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output hpe_pkg::work_t rdata_o
);
  import hpe_pkg::*;
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t             mem_q [Depth];
  logic [PtrW-1:0]   wp_q, rp_q;
  logic [PtrW:0]     cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + PtrW'(1);
      if (pop_i)  rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + (PtrW+1)'(1)) else $error("count step");
`endif
endmodule

/* hw/rtl/hpe_back.sv */
// Back end: emit one byte per cycle from a queued work entry while the output can advance.
module hpe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  hpe_pkg::work_t work_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);
  import hpe_pkg::*;

  // rem: head entry bits left; popped on its final byte, or without one if it makes none.
  logic            busy_q;
  logic [CntW-1:0] rem_q;
  logic [CntW-1:0] rem;
  logic [AccW+7:0] ext;
  logic [7:0]      byte_v;
  logic            fin_byte, final_b, emit, take;
  logic            ov_q, ol_q;
  logic [7:0]      ob_q;

  assign rem  = busy_q ? rem_q : work_i.n;
  // Pad with ones below the accumulator so a short tail yields EOS fill.
  assign ext  = {work_i.acc, 8'hff};
  assign byte_v = 8'(ext >> rem);
  assign take  = !ov_q || out_ready_i;
  // final_b: this byte ends the entry.
  assign final_b  = work_i.fin ? (rem <= CntW'(8)) : (rem < CntW'(16));
  assign emit     = !empty_i && take && (rem >= CntW'(8) || (work_i.fin && rem != '0));
  assign fin_byte = work_i.fin && rem <= CntW'(8);
  assign pop_o    = !empty_i && take && (final_b || (!work_i.fin && rem < CntW'(8)));

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ob_q <= byte_v;
      ol_q <= fin_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (take) ov_q <= emit;
      if (pop_o) busy_q <= 1'b0;
      else if (emit) begin
        busy_q <= 1'b1;
        rem_q  <= rem - CntW'(8);
      end
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(ob_q)) else $error("output dropped");
  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !empty_i) else $error("busy without entry");
  a_pop_emits_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && work_i.fin |-> emit && fin_byte) else $error("last entry popped without last byte");
`endif
endmodule

/* bench/hpe_tb_pkg.sv */
// Package: Huffman code tables used by the encoder testbench predictor.
package hpe_tb_pkg;

  // Code word per octet (RFC 7541 Appendix B), right-aligned.
  localparam logic [29:0] HuffCode [256] = '{
    30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,30'hfffffe7,
    30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,30'h3ffffffd,30'hfffffeb,
    30'hfffffec,
    30'hfffffed,30'hfffffee,30'hfffffef,30'hffffff0,30'hffffff1,30'hffffff2,30'h3ffffffe,
    30'hffffff3,
    30'hffffff4,30'hffffff5,30'hffffff6,30'hffffff7,30'hffffff8,30'hffffff9,30'hffffffa,
    30'hffffffb,
    30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,
    30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,30'h18,
    30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,
    30'h1e,30'h1f,30'h5c,30'hfb,30'h7ffc,30'h20,30'hffb,30'h3fc,
    30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,
    30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,
    30'h6b,30'h6c,30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,
    30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,30'h1ffc,30'h3ffc,30'h22,
    30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
    30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,
    30'h2b,30'h76,30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,
    30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,30'h3ffd,30'h1ffd,30'hffffffc,
    30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,
    30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,
    30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,
    30'h7fffe4,30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
    30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,
    30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
    30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,30'h7fffef,
    30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,
    30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,
    30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,
    30'h1ffffed,
    30'h7fff2,30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,
    30'hfffff2,
    30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,
    30'h7ffffe5,
    30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
    30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,30'h7ffff4,
    30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,
    30'h7ffffea,
    30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,30'h7fffff0,
    30'h3ffffee
  };

  // Code length in bits per octet.
  localparam int unsigned HuffLen [256] = '{
    13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
    28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
    6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
    5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
    13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
    7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
    15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
    6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
    20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
    24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
    22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
    21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
    26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
    19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
    20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
    26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26
  };

endpackage

/* bench/hpack_huffman_string_encoder_tb.sv */
// Testbench: HPACK Huffman string encoder, self-checking against a bit-level predictor.
module hpack_huffman_string_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpe_tb_pkg::*;

  typedef struct packed {
    logic [7:0] octet;
    logic       fin;
  } enc_byte_t;

  logic clk_i;
  logic rst_ni;

  hpe_sym_if  sym_ch ();
  hpe_byte_if byte_ch ();

  hpack_huffman_string_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (sym_ch.sink),
    .out_if (byte_ch.source)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Predictor state: bits not yet packed into a byte, right-aligned.
  logic [6:0]  pend_bits;
  int unsigned pend_cnt;
  enc_byte_t   byte_q[$];

  int unsigned n_sent, n_strings, n_bytes, n_mism;
  bit          fail;
  bit          rx_stall_en;

  // Append one octet's code and queue every byte it completes.
  function automatic void predict_octet(logic [7:0] sym, logic fin);
    logic [63:0] acc;
    int unsigned n, clen;
    enc_byte_t   b;
    clen = HuffLen[sym];
    acc  = (64'(pend_bits) << clen) | 64'(HuffCode[sym]);
    n    = pend_cnt + clen;
    while (n >= 8) begin
      b.octet = 8'(acc >> (n - 8));
      b.fin   = 1'b0;
      byte_q.push_back(b);
      n -= 8;
    end
    if (fin) begin
      // leftover bits padded with the EOS prefix (all ones)
      if (n > 0) begin
        b.octet = 8'((acc << (8 - n)) | (64'hff >> n));
        b.fin   = 1'b0;
        byte_q.push_back(b);
      end
      byte_q[$].fin = 1'b1;
      pend_bits = '0;
      pend_cnt  = 0;
      n_strings++;
    end else begin
      pend_bits = 7'(acc & ((64'd1 << n) - 1));
      pend_cnt  = n;
    end
  endfunction

  // Drive one transaction; holds valid until accepted.
  task automatic send_octet(logic [7:0] sym, logic fin);
    sym_ch.valid  <= 1'b1;
    sym_ch.symbol <= sym;
    sym_ch.last   <= fin;
    do @(posedge clk_i); while (!sym_ch.ready);
    predict_octet(sym, fin);
    n_sent++;
  endtask

  task automatic idle_cycles(int unsigned k);
    sym_ch.valid <= 1'b0;
    repeat (k) @(posedge clk_i);
  endtask

  // Bursty sender: random-length bursts, most of them preceded by a random gap.
  int unsigned burst_left;
  task automatic send_paced(logic [7:0] sym, logic fin);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
    burst_left--;
    send_octet(sym, fin);
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (byte_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall pattern: periodic windows plus random drops.
  int unsigned rx_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ch.ready <= 1'b0;
      rx_phase      <= 0;
    end else begin
      rx_phase      <= (rx_phase + 1) % 23;
      byte_ch.ready <= !rx_stall_en ||
                       ((rx_phase > 6) && ($urandom_range(0, 4) != 0));
    end
  end

  // Result checker: each output transaction against the oldest expected byte.
  always @(posedge clk_i) begin
    enc_byte_t exp_b;
    if (rst_ni && byte_ch.valid && byte_ch.ready) begin
      n_bytes++;
      if (byte_q.size() == 0) begin
        fail = 1'b1;
        n_mism++;
        if (n_mism <= 10)
          $display("%0t: unexpected byte %02h last=%0b", $realtime,
                   byte_ch.out_byte, byte_ch.out_last);
      end else begin
        exp_b = byte_q.pop_front();
        if (byte_ch.out_byte !== exp_b.octet || byte_ch.out_last !== exp_b.fin) begin
          fail = 1'b1;
          n_mism++;
          if (n_mism <= 10)
            $display("%0t: byte mismatch exp %02h/%0b got %02h/%0b", $realtime,
                     exp_b.octet, exp_b.fin, byte_ch.out_byte, byte_ch.out_last);
        end
      end
    end
  end

  // Directed: shortest and longest codes, all-bit octets, aligned and padded ends.
  task automatic test_directed();
    send_octet(8'd48, 1'b1);   // 5-bit code alone: three pad bits
    send_octet(8'd38, 1'b1);   // 8-bit code: byte-aligned end, no pad byte
    send_octet(8'd10, 1'b0);   // 30-bit code
    send_octet(8'd22, 1'b0);
    send_octet(8'd13, 1'b1);
    send_octet(8'd0,  1'b0);
    send_octet(8'd255, 1'b1);
    send_octet(8'd49, 1'b0);   // 5 bits pend, no output
    send_octet(8'd50, 1'b0);   // 10 bits: one byte out
    send_octet(8'd97, 1'b1);
    // 7 pending bits, then a 30-bit code on last: five bytes
    send_octet(8'd58, 1'b0);
    send_octet(8'd22, 1'b1);
    send_octet(8'd170, 1'b0);
    send_octet(8'd85, 1'b0);
    send_octet(8'd127, 1'b0);
    send_octet(8'd128, 1'b1);
    // two 8-bit codes, the second one last: aligned on 16 bits
    send_octet(8'd38, 1'b0);
    send_octet(8'd42, 1'b1);
    wait_drained();
  endtask

  // Random strings of 1..40 octets, mostly 1..12; mostly printable text, some any octet.
  task automatic test_random_strings(int unsigned target);
    int unsigned len, i;
    logic [7:0]  sym;
    while (n_sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 2) == 0) sym = 8'($urandom);
        else sym = 8'($urandom_range(32, 126));
        send_paced(sym, i == len - 1);
      end
    end
  endtask

  // Back-pressure: stalling receiver, a pause until all bytes have drained, then a run with no stall.
  task automatic test_backpressure(int unsigned target);
    rx_stall_en = 1'b1;
    test_random_strings(target);
    wait_drained();
    rx_stall_en = 1'b0;
    test_random_strings(target + 40);
    rx_stall_en = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    sym_ch.valid  = 1'b0;
    sym_ch.symbol = '0;
    sym_ch.last   = 1'b0;
    pend_bits = '0;
    pend_cnt  = 0;
    n_sent = 0; n_strings = 0; n_bytes = 0; n_mism = 0;
    fail = 1'b0; burst_left = 0; rx_stall_en = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    rx_stall_en = 1'b1;
    test_random_strings(200);
    test_backpressure(420);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d octets in %0d strings, %0d encoded bytes checked, %0d mismatches.",
             n_sent, n_strings, n_bytes, n_mism);
    if (!fail && byte_q.size() == 0) begin
      $display("hpack_huffman_string_encoder regression: pass");
    end else begin
      $display("hpack_huffman_string_encoder regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("hpack_huffman_string_encoder regression: fail");
    $finish;
  end

endmodule
